/* hw/rtl/b2r_pkg.sv */
// ---------------------------------------------------------------------------
// b2r_pkg
// Shared types and constants for the BMP to RGB565 converter: result kinds,
// the result word, header layout and default sizing.
// ---------------------------------------------------------------------------
package b2r_pkg;

   localparam int MAX_DIM_DEFAULT = 1024;

   // Thumbnail decimation factor; it must be a power of two.
   localparam int THUMB_DIVISOR = 4;
   localparam int THUMB_SHIFT   = $clog2(THUMB_DIVISOR);

   localparam logic [7:0] SIG_B = 8'h42;
   localparam logic [7:0] SIG_M = 8'h4D;

   localparam logic [5:0] HDR_SIG0   = 6'd0;
   localparam logic [5:0] HDR_SIG1   = 6'd1;
   localparam logic [5:0] WIDTH_POS  = 6'd18;
   localparam logic [5:0] WIDTH_END  = 6'd21;
   localparam logic [5:0] HEIGHT_POS = 6'd22;
   localparam logic [5:0] HEIGHT_END = 6'd25;
   localparam logic [5:0] HDR_LAST   = 6'd53;

   typedef enum logic [1:0] {
      KIND_PIXEL     = 2'd0,
      KIND_HEADER_OK = 2'd1,
      KIND_NOT_BMP   = 2'd2,
      KIND_BAD_DIM   = 2'd3
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] pixel_rgb565;
      logic [9:0]  dest_x;
      logic [9:0]  dest_y;
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic        last_pixel;
   } rsp_type;

endpackage

/* hw/rtl/bmp_to_rgb565_decimator.sv */
// ---------------------------------------------------------------------------
// bmp_to_rgb565_decimator
// Streaming converter from a 24-bit BMP byte stream to RGB565 pixels with
// destination coordinates, with an optional decimated thumbnail mode.
// ---------------------------------------------------------------------------
// The req channel takes one file byte per word; req_start_of_file marks the
// first byte of a file and restarts the header parse at that byte.
// The rsp channel returns zero or one word per input byte: header accepted
// with the image size, a signature or dimension rejection, or a pixel with
// its column and top-down row. The last pixel of an image carries
// rsp_last_pixel.
// The csr channel writes thumbnail_mode and is always ready; write it only
// while no file is in flight.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single parse stage between the input register and the result
// register. A result is valid in the cycle after the edge that moves its
// byte out of the input register.
// When the receiver stalls, the result register holds its word and the
// input register holds or takes at most one more byte; req_ready then stays
// low until rsp_ready returns.
// Reset empties both registers, clears the parser to the start of a header
// and clears thumbnail_mode.
// ---------------------------------------------------------------------------
module bmp_to_rgb565_decimator #(
   parameter int MAX_DIM = b2r_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_pixel_rgb565,
   output logic [9:0]  rsp_dest_x,
   output logic [9:0]  rsp_dest_y,
   output logic [10:0] rsp_image_width,
   output logic [10:0] rsp_image_height,
   output logic        rsp_last_pixel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_thumbnail_mode
);
   import b2r_pkg::*;

   logic       thumb_ff;
   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       sof_ff;
   logic       out_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    parse_word;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thumb_ff <= 1'b0;
      end else if (csr_valid) begin
         thumb_ff <= csr_thumbnail_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_file_byte;
         sof_ff  <= req_start_of_file;
      end
   end

   b2r_parse #(
      .MAX_DIM(MAX_DIM)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .file_byte     (byte_ff),
      .start_of_file (sof_ff),
      .thumbnail_mode(thumb_ff),
      .word_out      (parse_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= parse_word.valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= parse_word;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_pixel_rgb565 = rsp_ff.pixel_rgb565;
   assign rsp_dest_x       = rsp_ff.dest_x;
   assign rsp_dest_y       = rsp_ff.dest_y;
   assign rsp_image_width  = rsp_ff.image_width;
   assign rsp_image_height = rsp_ff.image_height;
   assign rsp_last_pixel   = rsp_ff.last_pixel;

`ifndef SYNTHESIS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(byte_ff) && $stable(sof_ff)))
      else $error("Stalled input word was lost or changed.");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_pixel) |-> (rsp_kind == KIND_PIXEL))
      else $error("Last-pixel flag on a non-pixel word.");

   a_dims_only_on_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_HEADER_OK)) |->
         ((rsp_image_width == 11'd0) && (rsp_image_height == 11'd0)))
      else $error("Image size on a word that is not a header acceptance.");

   a_no_pixel_on_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_PIXEL)) |->
         ((rsp_pixel_rgb565 == 16'd0) && (rsp_dest_x == 10'd0) && (rsp_dest_y == 10'd0)))
      else $error("Pixel fields set on a status word.");
`endif

endmodule

/* hw/rtl/b2r_parse.sv */
// ---------------------------------------------------------------------------
// b2r_parse
// Per-byte parser state: header check and dimension capture, row and pixel
// walk, color repack and thumbnail selection. The result word is
// combinational from the current byte and the state; the state advances on
// step.
// ---------------------------------------------------------------------------
module b2r_parse #(
   parameter int MAX_DIM = b2r_pkg::MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       file_byte,
   input  logic             start_of_file,
   input  logic             thumbnail_mode,
   output b2r_pkg::rsp_type word_out
);
   import b2r_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int RB_W  = $clog2(3 * MAX_DIM + 4);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXELS = 2'd1,
      PH_IDLE   = 2'd2
   } phase_type;

   function automatic logic dim_ok(logic [31:0] d);
      return (d != 32'd0) && !d[31] && (d <= 32'(MAX_DIM));
   endfunction

   function automatic logic [9:0] coord10(logic [DIM_W-1:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[9:0];
   endfunction

   phase_type        phase_ff, phase_in;
   logic [5:0]       hpos_ff, hpos_in;
   logic [31:0]      wgat_ff, wgat_in;
   logic [31:0]      hgat_ff, hgat_in;
   logic [RB_W-1:0]  rowbytes_ff, rowbytes_in;
   logic [RB_W-1:0]  stride_ff, stride_in;
   logic [RB_W-1:0]  rbp_ff, rbp_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] y_ff, y_in;
   logic [1:0]       cph_ff, cph_in;
   logic [7:0]       blue_ff, blue_in;
   logic [7:0]       green_ff, green_in;

   phase_type        phase_cur;
   logic [5:0]       hpos_cur;
   logic [31:0]      wg_cur, hg_cur, wg_upd, hg_upd;
   logic [5:0]       wofs, hofs;
   logic             sig_bad;
   logic [DIM_W-1:0] wid, hgt, wid_new, hgt_new;
   logic [RB_W-1:0]  w3_new, w3p_new, rbp_nxt;
   logic [DIM_W-1:0] xq, yq, wq, hq;
   logic             thumb_keep, thumb_last;
   logic [15:0]      rgb;
   rsp_type          word;

   assign phase_cur = start_of_file ? PH_HEADER : phase_ff;
   assign hpos_cur  = start_of_file ? 6'd0 : hpos_ff;
   assign wg_cur    = start_of_file ? 32'd0 : wgat_ff;
   assign hg_cur    = start_of_file ? 32'd0 : hgat_ff;

   assign sig_bad = ((hpos_cur == HDR_SIG0) && (file_byte != SIG_B)) ||
                    ((hpos_cur == HDR_SIG1) && (file_byte != SIG_M));

   assign wofs   = hpos_cur - WIDTH_POS;
   assign hofs   = hpos_cur - HEIGHT_POS;
   assign wg_upd = ((hpos_cur >= WIDTH_POS) && (hpos_cur <= WIDTH_END)) ?
                   (wg_cur | (32'(file_byte) << {wofs[1:0], 3'b000})) : wg_cur;
   assign hg_upd = ((hpos_cur >= HEIGHT_POS) && (hpos_cur <= HEIGHT_END)) ?
                   (hg_cur | (32'(file_byte) << {hofs[1:0], 3'b000})) : hg_cur;

   assign wid_new = wg_upd[DIM_W-1:0];
   assign hgt_new = hg_upd[DIM_W-1:0];
   assign w3_new  = RB_W'(wid_new) + (RB_W'(wid_new) << 1);
   assign w3p_new = w3_new + RB_W'(3);

   assign wid = wgat_ff[DIM_W-1:0];
   assign hgt = hgat_ff[DIM_W-1:0];

   assign xq = col_ff >> THUMB_SHIFT;
   assign yq = y_ff >> THUMB_SHIFT;
   assign wq = wid >> THUMB_SHIFT;
   assign hq = hgt >> THUMB_SHIFT;
   assign thumb_keep = ((col_ff & DIM_W'(THUMB_DIVISOR - 1)) == '0) &&
                       ((y_ff & DIM_W'(THUMB_DIVISOR - 1)) == '0) &&
                       (yq < hq) && (xq < wq);
   assign thumb_last = (y_ff == '0) && ((xq + DIM_W'(1)) == wq);

   assign rgb     = {file_byte[7:3], green_ff[7:2], blue_ff[7:3]};
   assign rbp_nxt = rbp_ff + RB_W'(1);

   always_comb begin
      phase_in    = phase_cur;
      hpos_in     = hpos_cur;
      wgat_in     = wg_cur;
      hgat_in     = hg_cur;
      rowbytes_in = rowbytes_ff;
      stride_in   = stride_ff;
      rbp_in      = rbp_ff;
      col_in      = col_ff;
      y_in        = y_ff;
      cph_in      = cph_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      word        = '0;

      case (phase_cur)
         PH_HEADER: begin
            if (sig_bad) begin
               word.valid = 1'b1;
               word.kind  = KIND_NOT_BMP;
               phase_in   = PH_IDLE;
            end else begin
               wgat_in = wg_upd;
               hgat_in = hg_upd;
               if (hpos_cur >= HDR_LAST) begin
                  word.valid = 1'b1;
                  if (!dim_ok(wg_upd) || !dim_ok(hg_upd)) begin
                     word.kind = KIND_BAD_DIM;
                     phase_in  = PH_IDLE;
                  end else begin
                     word.kind         = KIND_HEADER_OK;
                     word.image_width  = wg_upd[10:0];
                     word.image_height = hg_upd[10:0];
                     phase_in          = PH_PIXELS;
                     rowbytes_in       = w3_new;
                     stride_in         = {w3p_new[RB_W-1:2], 2'b00};
                     rbp_in            = '0;
                     col_in            = '0;
                     cph_in            = 2'd0;
                     y_in              = hgt_new - DIM_W'(1);
                  end
               end else begin
                  hpos_in = hpos_cur + 6'd1;
               end
            end
         end
         PH_PIXELS: begin
            if (rbp_ff < rowbytes_ff) begin
               case (cph_ff)
                  2'd0: begin
                     blue_in = file_byte;
                     cph_in  = 2'd1;
                  end
                  2'd1: begin
                     green_in = file_byte;
                     cph_in   = 2'd2;
                  end
                  default: begin
                     if (!thumbnail_mode) begin
                        word.valid        = 1'b1;
                        word.kind         = KIND_PIXEL;
                        word.pixel_rgb565 = rgb;
                        word.dest_x       = coord10(col_ff);
                        word.dest_y       = coord10(y_ff);
                        word.last_pixel   = (y_ff == '0) &&
                                            (col_ff == wid - DIM_W'(1));
                     end else if (thumb_keep) begin
                        word.valid        = 1'b1;
                        word.kind         = KIND_PIXEL;
                        word.pixel_rgb565 = rgb;
                        word.dest_x       = coord10(xq);
                        word.dest_y       = coord10(yq);
                        word.last_pixel   = thumb_last;
                     end
                     col_in = col_ff + DIM_W'(1);
                     cph_in = 2'd0;
                  end
               endcase
            end
            if (rbp_nxt == stride_ff) begin
               rbp_in = '0;
               col_in = '0;
               cph_in = 2'd0;
               y_in   = y_ff - DIM_W'(1);
               if (y_ff == '0) begin
                  phase_in = PH_IDLE;
               end
            end else begin
               rbp_in = rbp_nxt;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hpos_ff     <= '0;
         wgat_ff     <= '0;
         hgat_ff     <= '0;
         rowbytes_ff <= '0;
         stride_ff   <= '0;
         rbp_ff      <= '0;
         col_ff      <= '0;
         y_ff        <= '0;
         cph_ff      <= '0;
         blue_ff     <= '0;
         green_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hpos_ff     <= hpos_in;
         wgat_ff     <= wgat_in;
         hgat_ff     <= hgat_in;
         rowbytes_ff <= rowbytes_in;
         stride_ff   <= stride_in;
         rbp_ff      <= rbp_in;
         col_ff      <= col_in;
         y_ff        <= y_in;
         cph_ff      <= cph_in;
         blue_ff     <= blue_in;
         green_ff    <= green_in;
      end
   end

   assign word_out = word;

endmodule
